/* hdl/i2cst_pkg.sv */
package i2cst_pkg;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_STARTED   = 2'd1,
    PH_RECEIVING = 2'd2,
    PH_SENDING   = 2'd3
  } phase_t;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_OVERRUN = 3'd1;
  localparam logic [2:0] ERR_NOADDR  = 3'd2;
  localparam logic [2:0] ERR_NODATA  = 3'd3;
  localparam logic [2:0] ERR_TOOLONG = 3'd4;

  localparam logic [1:0] KIND_BUS    = 2'd0;
  localparam logic [1:0] KIND_MSG    = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [7:0] THRESHOLD_RESET = 8'd3;

  typedef struct packed {
    logic       func;
    logic       overrun_flag;
    logic       byte_ready;
    logic [7:0] rx_byte;
    logic       start_seen;
    logic       stop_seen;
    logic       is_data;
    logic       is_read;
    logic [7:0] reply_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       tx_valid;
    logic       release_clock;
    logic       last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUS,
    ST_MSG_RD,
    ST_MSG_OUT,
    ST_REP_OUT,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_TX_RD
  } seq_t;

endpackage

/* hdl/i2cst_ram.sv */
module i2cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/i2c_slave_transaction_handler.sv */
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_ready     | i2cst_pkg::in_word_t
// out     | output    | out_valid / out_ready   | i2cst_pkg::out_word_t
// cfg     | input     | cfg_valid / cfg_ready   | error report threshold, 8 bits
// A queue word is taken while idle. A bus event emits its bus word from the bus state,
// each report word is one output, and each message word takes a memory read and an output.
// Starting a reply copies every reply slot with a read and a write
// through the queue and reply memories, then sends the first byte.
// Reset clears the control state; the queue holds its reset zeros through valid bits.
// The output register stalls the sequencer while it holds a word and out_ready is low.
module i2c_slave_transaction_handler #(
  parameter int RX_DEPTH  = 32,
  parameter int REPLY_LEN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cst_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cst_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  localparam int RAW = $clog2(RX_DEPTH);
  localparam int QAW = (REPLY_LEN > 1) ? $clog2(REPLY_LEN) : 1;
  localparam int QD  = 1 << QAW;

  i2cst_pkg::seq_t   seq, seq_next;
  i2cst_pkg::phase_t phase, phase_next;
  i2cst_pkg::in_word_t ev;
  logic [7:0] threshold;
  logic [5:0] rx_count, rx_count_next;
  logic [7:0] event_counter, event_counter_next;
  logic [7:0] error_counter, error_counter_next;
  logic [2:0] last_error, last_error_next;
  logic [3:0] rq_count, rq_count_next;
  logic [3:0] out_index, out_index_next;
  logic [REPLY_LEN-1:0] rq_written;
  logic to_send, to_send_next;
  logic msg_pend, msg_pend_next;
  logic [5:0] msg_len, msg_len_next;
  logic [5:0] idx, idx_next;
  logic [1:0] rep_idx, rep_idx_next;
  logic [7:0] tx_hold, tx_hold_next;

  logic       ov_load;
  i2cst_pkg::out_word_t ov_word;
  logic       out_free;

  logic           rx_we;
  logic [RAW-1:0] rx_waddr, rx_raddr;
  logic [7:0]     rx_wdata, rx_rdata;
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [7:0]     q_wdata, q_rdata;
  logic           o_we;
  logic [QAW-1:0] o_waddr, o_raddr;
  logic [7:0]     o_wdata, o_rdata;
  logic [QAW-1:0] copy_src;
  logic           copy_src_valid;
  logic           copy_src_valid_q;

  i2cst_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
    .raddr(rx_raddr), .rdata(rx_rdata)
  );
  i2cst_ram #(.WIDTH(8), .DEPTH(QD)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );
  i2cst_ram #(.WIDTH(8), .DEPTH(QD)) u_reply_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (seq == i2cst_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Padding source for reply slot idx: own byte, last queued byte, or last slot.
  always_comb begin
    if ({26'd0, idx} < 32'(rq_count)) begin
      copy_src = idx[QAW-1:0];
    end else if (rq_count != 4'd0) begin
      copy_src = QAW'(rq_count - 4'd1);
    end else begin
      copy_src = QAW'(REPLY_LEN - 1);
    end
    copy_src_valid = rq_written[copy_src];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= i2cst_pkg::ST_IDLE;
      phase <= i2cst_pkg::PH_IDLE;
      threshold <= i2cst_pkg::THRESHOLD_RESET;
      rx_count <= '0;
      event_counter <= '0;
      error_counter <= '0;
      last_error <= i2cst_pkg::ERR_NONE;
      rq_count <= '0;
      out_index <= '0;
      rq_written <= '0;
      out_valid <= 1'b0;
    end else begin
      seq <= seq_next;
      phase <= phase_next;
      rx_count <= rx_count_next;
      event_counter <= event_counter_next;
      error_counter <= error_counter_next;
      last_error <= last_error_next;
      rq_count <= rq_count_next;
      out_index <= out_index_next;
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (q_we) begin
        rq_written[q_waddr] <= 1'b1;
      end
      if (ov_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev <= in_data;
    end
    if (ov_load) begin
      out_data <= ov_word;
    end
    to_send <= to_send_next;
    msg_pend <= msg_pend_next;
    msg_len <= msg_len_next;
    idx <= idx_next;
    rep_idx <= rep_idx_next;
    tx_hold <= tx_hold_next;
    copy_src_valid_q <= copy_src_valid;
  end

  always_comb begin
    logic       dr, msg, written, rel, txv, err_hit;
    logic [7:0] txval;
    logic [2:0] code;
    seq_next = seq;
    phase_next = phase;
    rx_count_next = rx_count;
    event_counter_next = event_counter;
    error_counter_next = error_counter;
    last_error_next = last_error;
    rq_count_next = rq_count;
    out_index_next = out_index;
    to_send_next = to_send;
    msg_pend_next = msg_pend;
    msg_len_next = msg_len;
    idx_next = idx;
    rep_idx_next = rep_idx;
    tx_hold_next = tx_hold;
    ov_load = 1'b0;
    ov_word = '0;
    rx_we = 1'b0;
    rx_waddr = rx_count[RAW-1:0];
    rx_wdata = ev.rx_byte;
    rx_raddr = idx[RAW-1:0];
    q_we = 1'b0;
    q_waddr = rq_count[QAW-1:0];
    q_wdata = in_data.reply_byte;
    q_raddr = copy_src;
    o_we = 1'b0;
    o_waddr = idx[QAW-1:0];
    o_wdata = copy_src_valid_q ? q_rdata : 8'd0;
    o_raddr = out_index[QAW-1:0];
    dr = ev.byte_ready;
    msg = 1'b0;
    written = 1'b0;
    rel = 1'b0;
    txv = 1'b0;
    txval = 8'd0;
    err_hit = 1'b0;
    code = i2cst_pkg::ERR_NONE;

    unique case (seq)
      i2cst_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.func) begin
            if (32'(rq_count) < REPLY_LEN) begin
              q_we = 1'b1;
              rq_count_next = rq_count + 4'd1;
            end
          end else begin
            seq_next = i2cst_pkg::ST_BUS;
          end
        end
      end

      i2cst_pkg::ST_BUS: begin
        // The reply memory was read at out_index during the previous cycle.
        if (out_free) begin
          to_send_next = 1'b0;
          if (ev.overrun_flag) begin
            phase_next = i2cst_pkg::PH_IDLE;
            err_hit = 1'b1;
            code = i2cst_pkg::ERR_OVERRUN;
          end else begin
            unique case (phase)
              i2cst_pkg::PH_IDLE: begin
                if (ev.start_seen) begin
                  event_counter_next = 8'd1;
                  rx_count_next = '0;
                  if (dr) begin
                    if (ev.is_data) begin
                      err_hit = 1'b1;
                      code = i2cst_pkg::ERR_NOADDR;
                    end else if (ev.is_read) begin
                      phase_next = i2cst_pkg::PH_SENDING;
                      dr = 1'b0;
                      to_send_next = 1'b1;
                    end else begin
                      phase_next = i2cst_pkg::PH_RECEIVING;
                    end
                  end else begin
                    phase_next = i2cst_pkg::PH_STARTED;
                  end
                end
              end
              i2cst_pkg::PH_STARTED: begin
                if (ev.stop_seen) begin
                  event_counter_next = event_counter + 8'd1;
                  if (dr) begin
                    if (!ev.is_data) begin
                      msg = 1'b1;
                    end else begin
                      err_hit = 1'b1;
                      code = i2cst_pkg::ERR_NODATA;
                    end
                  end
                  phase_next = i2cst_pkg::PH_IDLE;
                end else if (dr) begin
                  event_counter_next = event_counter + 8'd1;
                  if (!ev.is_data) begin
                    if (!ev.is_read) begin
                      phase_next = i2cst_pkg::PH_RECEIVING;
                    end else begin
                      phase_next = i2cst_pkg::PH_SENDING;
                      to_send_next = 1'b1;
                      dr = 1'b0;
                    end
                  end else begin
                    err_hit = 1'b1;
                    code = i2cst_pkg::ERR_NODATA;
                    phase_next = i2cst_pkg::PH_IDLE;
                  end
                end
              end
              i2cst_pkg::PH_SENDING: begin
                if (32'(out_index) < REPLY_LEN) begin
                  txval = o_rdata;
                  txv = 1'b1;
                  out_index_next = out_index + 4'd1;
                  written = 1'b1;
                end else begin
                  phase_next = i2cst_pkg::PH_IDLE;
                end
              end
              default: begin
                if (ev.stop_seen || dr) begin
                  event_counter_next = event_counter + 8'd1;
                end
                if (ev.stop_seen) begin
                  if (dr) begin
                    if (ev.is_data) begin
                      if (32'(rx_count) < RX_DEPTH) begin
                        rx_we = 1'b1;
                        rx_count_next = rx_count + 6'd1;
                      end
                      msg = 1'b1;
                    end else begin
                      err_hit = 1'b1;
                      code = i2cst_pkg::ERR_NODATA;
                    end
                  end else begin
                    msg = 1'b1;
                  end
                  phase_next = i2cst_pkg::PH_IDLE;
                end else if (dr) begin
                  if (ev.is_data) begin
                    if (32'(rx_count) < RX_DEPTH) begin
                      rx_we = 1'b1;
                      rx_count_next = rx_count + 6'd1;
                    end
                  end else if (ev.is_read) begin
                    phase_next = i2cst_pkg::PH_SENDING;
                    msg = 1'b1;
                    to_send_next = 1'b1;
                    dr = 1'b0;
                  end else begin
                    err_hit = 1'b1;
                    code = i2cst_pkg::ERR_NODATA;
                    phase_next = i2cst_pkg::PH_IDLE;
                  end
                end
              end
            endcase
          end

          rel = dr || written;
          if (err_hit) begin
            if (error_counter_next != 8'hFF) begin
              error_counter_next = error_counter_next + 8'd1;
            end
            last_error_next = code;
          end
          if (32'(rx_count_next) > RX_DEPTH - 2 && !msg) begin
            phase_next = i2cst_pkg::PH_IDLE;
            if (error_counter_next != 8'hFF) begin
              error_counter_next = error_counter_next + 8'd1;
            end
            last_error_next = i2cst_pkg::ERR_TOOLONG;
          end

          msg_pend_next = 1'b0;
          idx_next = '0;
          rep_idx_next = '0;
          if (msg) begin
            msg_pend_next = 1'b1;
            msg_len_next = rx_count_next;
          end

          if (to_send_next) begin
            // Bus result is held until the reply copy has filled every slot, and then carries slot zero.
            out_index_next = 4'd1;
            seq_next = i2cst_pkg::ST_COPY_RD;
          end else begin
            ov_load = 1'b1;
            ov_word.kind = i2cst_pkg::KIND_BUS;
            ov_word.value = txv ? txval : 8'd0;
            ov_word.tx_valid = txv;
            ov_word.release_clock = rel;
            if (msg) begin
              seq_next = i2cst_pkg::ST_MSG_RD;
            end else if (error_counter_next >= threshold) begin
              seq_next = i2cst_pkg::ST_REP_OUT;
            end else begin
              ov_word.last = 1'b1;
              seq_next = i2cst_pkg::ST_IDLE;
            end
          end
        end
      end

      i2cst_pkg::ST_COPY_RD: begin
        seq_next = i2cst_pkg::ST_COPY_WR;
      end

      i2cst_pkg::ST_COPY_WR: begin
        o_we = 1'b1;
        if (idx == 6'd0) begin
          tx_hold_next = o_wdata;
        end
        if (32'(idx) == REPLY_LEN - 1) begin
          rq_count_next = '0;
          idx_next = '0;
          seq_next = i2cst_pkg::ST_TX_RD;
        end else begin
          idx_next = idx + 6'd1;
          seq_next = i2cst_pkg::ST_COPY_RD;
        end
      end

      i2cst_pkg::ST_TX_RD: begin
        if (out_free) begin
          ov_load = 1'b1;
          ov_word.kind = i2cst_pkg::KIND_BUS;
          ov_word.value = tx_hold;
          ov_word.tx_valid = 1'b1;
          ov_word.release_clock = 1'b1;
          if (msg_pend) begin
            seq_next = i2cst_pkg::ST_MSG_RD;
          end else if (error_counter >= threshold) begin
            seq_next = i2cst_pkg::ST_REP_OUT;
          end else begin
            ov_word.last = 1'b1;
            seq_next = i2cst_pkg::ST_IDLE;
          end
        end
      end

      i2cst_pkg::ST_MSG_RD: begin
        seq_next = i2cst_pkg::ST_MSG_OUT;
      end

      i2cst_pkg::ST_MSG_OUT: begin
        if (out_free) begin
          ov_load = 1'b1;
          ov_word.kind = i2cst_pkg::KIND_MSG;
          if (idx < msg_len) begin
            ov_word.value = rx_rdata;
            idx_next = idx + 6'd1;
            seq_next = i2cst_pkg::ST_MSG_RD;
          end else begin
            ov_word.value = event_counter;
            ov_word.last = 1'b1;
            rx_count_next = '0;
            seq_next = i2cst_pkg::ST_IDLE;
          end
        end
      end

      i2cst_pkg::ST_REP_OUT: begin
        if (out_free) begin
          ov_load = 1'b1;
          ov_word.kind = i2cst_pkg::KIND_REPORT;
          rep_idx_next = rep_idx + 2'd1;
          case (rep_idx)
            2'd0: ov_word.value = error_counter;
            2'd1: ov_word.value = {5'd0, last_error};
            default: begin
              ov_word.value = event_counter;
              ov_word.last = 1'b1;
              error_counter_next = '0;
              seq_next = i2cst_pkg::ST_IDLE;
            end
          endcase
        end
      end

      default: seq_next = i2cst_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/i2cst_checker.sv */
module i2cst_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input i2cst_pkg::in_word_t  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cst_pkg::out_word_t out_data
);

  // Only bus actions may carry transmit or clock release flags.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != i2cst_pkg::KIND_BUS |->
      !out_data.tx_valid && !out_data.release_clock)
    else $error("flags on non-bus word");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.tx_valid && out_data.kind == i2cst_pkg::KIND_BUS |->
      out_data.value == 8'd0)
    else $error("bus value without transmit");

  // A bus event is never ready again in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.func |=> !in_ready)
    else $error("bus event accepted too fast");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

endmodule

bind i2c_slave_transaction_handler i2cst_props u_i2cst_props (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

/* sim/i2cst_checker.sv */
`timescale 1ns / 100ps

module i2cst_checker #(
  parameter int RX_DEPTH  = 32,
  parameter int REPLY_LEN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  i2cst_pkg::in_word_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  i2cst_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  output int                   errors,
  output int                   pending
);

  i2cst_pkg::out_word_t expected_q[$];
  logic [7:0]           threshold;
  i2cst_pkg::phase_t    phase;
  logic [7:0]           rx_mem[RX_DEPTH];
  int                   rx_count;
  logic [7:0]           event_cnt;
  logic [7:0]           error_cnt;
  logic [2:0]           last_err;
  logic [7:0]           reply_q[REPLY_LEN];
  int                   reply_cnt;
  logic [7:0]           reply_mem[REPLY_LEN];
  int                   reply_idx;

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic push(input logic [1:0] k, input logic [7:0] v, input logic t,
                      input logic r);
    i2cst_pkg::out_word_t w;
    w.kind = k;
    w.value = v;
    w.tx_valid = t;
    w.release_clock = r;
    w.last = 1'b0;
    expected_q.push_back(w);
  endtask

  task automatic count_error(input logic [2:0] code);
    if (error_cnt != 8'hFF) error_cnt++;
    last_err = code;
  endtask

  task automatic keep_byte(input logic [7:0] b);
    if (rx_count < RX_DEPTH) begin
      rx_mem[rx_count] = b;
      rx_count = (rx_count + 1) & 63;
    end
  endtask

  // Works out every word that one bus event or queue word should produce.
  task automatic predict_results(input i2cst_pkg::in_word_t w);
    logic       br, written, msg, to_send, txv, rel;
    logic [7:0] txval;
    int         first;
    br = w.byte_ready;
    written = 1'b0; msg = 1'b0; to_send = 1'b0; txv = 1'b0; txval = 8'd0;
    if (w.func) begin
      if (reply_cnt < REPLY_LEN) begin
        reply_q[reply_cnt] = w.reply_byte;
        reply_cnt++;
      end
      return;
    end
    if (w.overrun_flag) begin
      phase = i2cst_pkg::PH_IDLE;
      count_error(i2cst_pkg::ERR_OVERRUN);
    end else begin
      case (phase)
        i2cst_pkg::PH_IDLE: begin
          if (w.start_seen) begin
            event_cnt = 8'd1;
            rx_count = 0;
            if (br) begin
              if (w.is_data) begin
                phase = i2cst_pkg::PH_IDLE;
                count_error(i2cst_pkg::ERR_NOADDR);
              end else if (w.is_read) begin
                phase = i2cst_pkg::PH_SENDING;
                br = 1'b0;
                to_send = 1'b1;
              end else begin
                phase = i2cst_pkg::PH_RECEIVING;
              end
            end else begin
              phase = i2cst_pkg::PH_STARTED;
            end
          end
        end
        i2cst_pkg::PH_STARTED: begin
          if (w.stop_seen) begin
            event_cnt++;
            if (br) begin
              if (!w.is_data) msg = 1'b1;
              else count_error(i2cst_pkg::ERR_NODATA);
            end
            phase = i2cst_pkg::PH_IDLE;
          end else if (br) begin
            event_cnt++;
            if (!w.is_data) begin
              if (!w.is_read) begin
                phase = i2cst_pkg::PH_RECEIVING;
              end else begin
                phase = i2cst_pkg::PH_SENDING;
                to_send = 1'b1;
                br = 1'b0;
              end
            end else begin
              count_error(i2cst_pkg::ERR_NODATA);
              phase = i2cst_pkg::PH_IDLE;
            end
          end
        end
        i2cst_pkg::PH_SENDING: begin
          if (reply_idx < REPLY_LEN) begin
            txval = reply_mem[reply_idx];
            txv = 1'b1;
            reply_idx++;
            written = 1'b1;
          end else begin
            phase = i2cst_pkg::PH_IDLE;
          end
        end
        default: begin
          if (w.stop_seen) begin
            event_cnt++;
            if (br) begin
              if (w.is_data) begin
                keep_byte(w.rx_byte);
                msg = 1'b1;
              end else begin
                count_error(i2cst_pkg::ERR_NODATA);
              end
            end else begin
              msg = 1'b1;
            end
            phase = i2cst_pkg::PH_IDLE;
          end else if (br) begin
            event_cnt++;
            if (w.is_data) begin
              keep_byte(w.rx_byte);
            end else if (w.is_read) begin
              phase = i2cst_pkg::PH_SENDING;
              msg = 1'b1;
              to_send = 1'b1;
              br = 1'b0;
            end else begin
              count_error(i2cst_pkg::ERR_NODATA);
              phase = i2cst_pkg::PH_IDLE;
            end
          end
        end
      endcase
    end
    rel = br | written;
    if (rx_count > RX_DEPTH - 2 && !msg) begin
      phase = i2cst_pkg::PH_IDLE;
      count_error(i2cst_pkg::ERR_TOOLONG);
    end
    // The bus action word comes first but depends on the reply build below.
    first = expected_q.size();
    push(i2cst_pkg::KIND_BUS, 8'd0, 1'b0, 1'b0);
    if (msg) begin
      for (int i = 0; i < rx_count && i < RX_DEPTH; i++)
        push(i2cst_pkg::KIND_MSG, rx_mem[i], 1'b0, 1'b0);
      push(i2cst_pkg::KIND_MSG, event_cnt, 1'b0, 1'b0);
      rx_count = 0;
    end else if (error_cnt >= threshold) begin
      push(i2cst_pkg::KIND_REPORT, error_cnt, 1'b0, 1'b0);
      push(i2cst_pkg::KIND_REPORT, {5'd0, last_err}, 1'b0, 1'b0);
      push(i2cst_pkg::KIND_REPORT, event_cnt, 1'b0, 1'b0);
      error_cnt = 8'd0;
    end
    if (to_send) begin
      for (int i = 0; i < REPLY_LEN; i++) begin
        if (i < reply_cnt) reply_mem[i] = reply_q[i];
        else if (reply_cnt != 0) reply_mem[i] = reply_q[reply_cnt - 1];
        else reply_mem[i] = reply_q[REPLY_LEN - 1];
      end
      reply_cnt = 0;
      reply_idx = 1;
      txval = reply_mem[0];
      txv = 1'b1;
      rel = 1'b1;
    end
    expected_q[first].value = txv ? txval : 8'd0;
    expected_q[first].tx_valid = txv;
    expected_q[first].release_clock = rel;
    expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    i2cst_pkg::out_word_t e;
    if (rst) begin
      errors = 0;
      expected_q.delete();
      threshold = i2cst_pkg::THRESHOLD_RESET;
      phase = i2cst_pkg::PH_IDLE;
      rx_count = 0;
      event_cnt = 8'd0;
      error_cnt = 8'd0;
      last_err = i2cst_pkg::ERR_NONE;
      for (int i = 0; i < REPLY_LEN; i++) reply_q[i] = 8'd0;
      reply_cnt = 0;
      reply_idx = 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", out_data.value, 8'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_data.kind !== e.kind)
            report("kind", {6'd0, out_data.kind}, {6'd0, e.kind});
          if (out_data.value !== e.value) report("value", out_data.value, e.value);
          if (out_data.tx_valid !== e.tx_valid)
            report("tx_valid", {7'd0, out_data.tx_valid}, {7'd0, e.tx_valid});
          if (out_data.release_clock !== e.release_clock)
            report("release_clock", {7'd0, out_data.release_clock},
                   {7'd0, e.release_clock});
          if (out_data.last !== e.last)
            report("last", {7'd0, out_data.last}, {7'd0, e.last});
        end
      end
      if (in_valid && in_ready) predict_results(in_data);
    end
    pending = expected_q.size();
  end

endmodule

/* sim/tb_i2c_slave_transaction_handler.sv */
`timescale 1ns / 100ps

module tb_i2c_slave_transaction_handler;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  i2cst_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  i2cst_pkg::out_word_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [7:0]           cfg_data;
  int                   errors;
  int                   pending;
  int                   words_sent;
  logic                 calm;
  int                   hold_left;
  logic                 hold_done;

  i2c_slave_transaction_handler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  i2cst_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off partway through the run.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_sent >= 70) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic send_word(input i2cst_pkg::in_word_t w);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    words_sent++;
  endtask

  task automatic bus_event(input int ovr, input int br, input int b,
                           input int st, input int sp, input int d, input int r);
    i2cst_pkg::in_word_t w;
    w = i2cst_pkg::in_word_t'(23'($urandom));
    w.func = 1'b0;
    w.overrun_flag = ovr[0];
    w.byte_ready = br[0];
    w.rx_byte = b[7:0];
    w.start_seen = st[0];
    w.stop_seen = sp[0];
    w.is_data = d[0];
    w.is_read = r[0];
    send_word(w);
  endtask

  task automatic queue_byte(input int b);
    i2cst_pkg::in_word_t w;
    w = i2cst_pkg::in_word_t'(23'($urandom));
    w.func = 1'b1;
    w.reply_byte = b[7:0];
    send_word(w);
  endtask

  // Register writes happen only with the block drained and quiet.
  task automatic set_threshold(input int t);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= t[7:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_message(input int n);
    bus_event(0, 1, $urandom, 1, 0, 0, 0);
    for (int i = 0; i < n; i++) bus_event(0, 1, $urandom, 0, 0, 1, 0);
    if ($urandom_range(0, 1)) bus_event(0, 1, $urandom, 0, 1, 1, 0);
    else bus_event(0, 0, $urandom, 0, 1, $urandom, $urandom);
  endtask

  task automatic read_message(input int k, input int m);
    for (int i = 0; i < k; i++) queue_byte($urandom);
    bus_event(0, 1, $urandom, 1, 0, 0, 1);
    for (int i = 0; i < m; i++) bus_event(0, $urandom, $urandom, 0, 0, $urandom, $urandom);
  endtask

  initial begin
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 8'd0;
    calm = 1'b0;
    words_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A reply with an empty queue sends the zero last slot.
    set_threshold(1);
    bus_event(0, 1, 0, 1, 0, 0, 1);
    bus_event(0, 0, 0, 0, 0, 0, 0);
    queue_byte(0);
    queue_byte('hFF);
    queue_byte('h5A);
    bus_event(0, 1, 0, 1, 0, 0, 1);
    for (int i = 0; i < 8; i++) bus_event(0, 1, 'hFF, 0, 0, 1, 1);
    bus_event(0, 0, 0, 1, 0, 0, 0);
    bus_event(0, 1, 0, 0, 0, 0, 0);
    bus_event(0, 1, 0, 0, 0, 1, 0);
    bus_event(0, 1, 'hFF, 0, 1, 1, 0);
    bus_event(0, 1, 'hFF, 1, 0, 1, 0);
    bus_event(1, 1, 'hFF, 1, 1, 1, 1);
    bus_event(0, 0, 0, 1, 0, 0, 0);
    bus_event(0, 1, 0, 0, 1, 0, 0);
    bus_event(0, 0, 0, 1, 0, 0, 0);
    bus_event(0, 1, 0, 0, 1, 1, 0);
    bus_event(0, 1, 0, 1, 0, 0, 0);
    bus_event(0, 1, 0, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++) queue_byte(i);
    bus_event(0, 1, 0, 1, 0, 0, 0);
    bus_event(0, 1, 'hC3, 0, 0, 0, 1);

    // Random part: mostly well-formed transfers, some noise, four thresholds.
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: set_threshold(255);
        1: set_threshold(3);
        2: set_threshold($urandom_range(1, 6));
        default: set_threshold(1);
      endcase
      calm = (seg == 2);
      for (int k = 0; k < 3; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) write_message(($urandom_range(0, 19) == 0) ? 33 : $urandom_range(0, 4));
        else if (pick < 70) read_message($urandom_range(0, 9), $urandom_range(0, 10));
        else for (int j = 0; j < 3; j++)
          bus_event(int'($urandom_range(0, 9) == 0), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/i2cst_pkg.sv
hdl/i2cst_ram.sv
hdl/i2c_slave_transaction_handler.sv
hdl/i2cst_checker.sv
sim/i2cst_checker.sv
sim/tb_i2c_slave_transaction_handler.sv
